@@ hw/rtl/box_overlap_pair_finder_macros.svh @@
// assertion macros for the box overlap pair finder
// expects clk and rst in the scope of use
`ifndef BOX_OVERLAP_PAIR_FINDER_MACROS_SVH
`define BOX_OVERLAP_PAIR_FINDER_MACROS_SVH

// same-cycle implication, held off during reset
`define BOPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define BOPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bopf_pkg.sv @@
// shared types and constants of the box overlap pair finder
// no dependencies
package bopf_pkg;

  // bounds per box: min_x, max_x, min_y, max_y, min_z, max_z
  localparam int NUM_BOUNDS = 6;
  localparam int NUM_AXES   = 3;

  // s_tuser bit positions
  localparam int S_USER_W   = 2;
  localparam int USER_START = 0;
  localparam int USER_PRIO  = 1;

  // job queue status
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

@@ hw/rtl/bopf_ram.sv @@
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module bopf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/bopf_queue.sv @@
// two-entry job queue between front and back
// depends on bopf_pkg
module bopf_queue #(
  parameter int WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   wdata,
  input  logic               pop,
  output logic [WIDTH-1:0]   rdata,
  output bopf_pkg::qstat_t   q_stat
);
  import bopf_pkg::*;

  logic [WIDTH-1:0] slot [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= wdata;
    end
  end

  assign rdata        = slot[rptr];
  assign q_stat.empty = (fill == 2'd0);
  assign q_stat.full  = (fill == 2'd2);

endmodule

@@ hw/rtl/bopf_front.sv @@
// front part: takes boxes, assigns set positions, stores boxes, queues jobs
// depends on bopf_pkg
module bopf_front #(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 24,
  parameter int IDX_W      = 6,
  parameter int JOB_W      = 151,
  parameter int S_DATA_W   = 144
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [S_DATA_W-1:0]           s_tdata,
  input  logic [bopf_pkg::S_USER_W-1:0] s_tuser,
  input  logic                          scan_idle,
  input  bopf_pkg::qstat_t              q_stat,
  output logic                          q_push,
  output logic [JOB_W-1:0]              q_wdata,
  output logic                          ram_we,
  output logic [IDX_W-1:0]              ram_waddr,
  output logic [JOB_W-IDX_W-1:0]        ram_wdata
);
  import bopf_pkg::*;

  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int BOX_W = NUM_BOUNDS * COORD_BITS;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             start;
  logic             store_full;
  logic             no_store;
  logic [IDX_W-1:0] pos;
  logic             accept;
  logic [BOX_W:0]   entry;

  assign start      = s_tuser[USER_START];
  assign store_full = (count == CNT_W'(MAX_BOXES));
  assign no_store   = !start && store_full;

  always_comb begin
    if (start) begin
      pos = '0;
    end else if (store_full) begin
      pos = IDX_W'(MAX_BOXES - 1);
    end else begin
      pos = count[IDX_W-1:0];
    end
  end

  // a new set may only begin once no queued or running job still reads the store
  assign s_tready = !q_stat.full && (!start || (q_stat.empty && scan_idle));
  assign accept   = s_tvalid && s_tready;

  assign entry     = {s_tuser[USER_PRIO], s_tdata[BOX_W-1:0]};
  assign q_push    = accept;
  assign q_wdata   = {pos, entry};
  assign ram_we    = accept && !no_store;
  assign ram_waddr = pos;
  assign ram_wdata = entry;

  always_comb begin
    count_next = count;
    if (accept && !no_store) begin
      count_next = CNT_W'(pos) + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

@@ hw/rtl/bopf_back.sv @@
// back part: scans stored boxes newest first, tests overlap, emits centers
// depends on bopf_pkg
module bopf_back #(
  parameter int COORD_BITS = 24,
  parameter int IDX_W      = 6,
  parameter int JOB_W      = 151,
  parameter int M_DATA_W   = 88
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bopf_pkg::qstat_t       q_stat,
  input  logic [JOB_W-1:0]       q_rdata,
  output logic                   q_pop,
  output logic                   scan_idle,
  output logic                   ram_re,
  output logic [IDX_W-1:0]       ram_raddr,
  input  logic [JOB_W-IDX_W-1:0] ram_rdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_DATA_W-1:0]    m_tdata,
  output logic                   m_tlast
);
  import bopf_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int BOX_W = NUM_BOUNDS * CB;

  // job being scanned
  logic [BOX_W-1:0] job_box;
  logic             job_prio;
  logic [IDX_W-1:0] job_pos;
  logic             active;
  logic [IDX_W-1:0] rd_idx;

  // compare stage
  logic             v1;
  logic [IDX_W-1:0] idx1;
  logic             last1;

  logic                 axis_ok [NUM_AXES];
  logic signed [CB-1:0] cand_lo [NUM_AXES];
  logic signed [CB-1:0] cand_hi [NUM_AXES];
  logic                 hit;
  logic                 hit_take;
  logic                 stall;

  // held hit, released once it is known whether it closes the run
  logic                 pend_v;
  logic                 pend_final;
  logic signed [CB-1:0] pend_lo [NUM_AXES];
  logic signed [CB-1:0] pend_hi [NUM_AXES];
  logic [IDX_W-1:0]     pend_new;
  logic [IDX_W-1:0]     pend_old;
  logic                 pend_go;
  logic                 out_free;

  logic [CB:0]      out_c [NUM_AXES];
  logic [IDX_W-1:0] out_new;
  logic [IDX_W-1:0] out_old;

  assign out_free  = !m_tvalid || m_tready;
  assign q_pop     = !q_stat.empty && !active && !v1;
  assign scan_idle = !active && !v1;
  assign ram_re    = active && !stall;
  assign ram_raddr = rd_idx;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      logic signed [CB-1:0] jl, jh, sl, sh;
      jl = job_box[2*a*CB +: CB];
      jh = job_box[(2*a+1)*CB +: CB];
      sl = ram_rdata[2*a*CB +: CB];
      sh = ram_rdata[(2*a+1)*CB +: CB];
      axis_ok[a] = (jl <= sl && sl <= jh) || (jl <= sh && sh <= jh) ||
                   (sl <= jl && jl <= sh) || (sl <= jh && jh <= sh);
      cand_lo[a] = (jl > sl) ? jl : sl;
      cand_hi[a] = (jh < sh) ? jh : sh;
    end
  end

  assign hit = v1 && axis_ok[0] && axis_ok[1] && axis_ok[2] &&
               !(job_prio && ram_rdata[BOX_W]);
  assign pend_go  = pend_v && out_free && (pend_final || hit);
  assign stall    = hit && pend_v && !pend_go;
  assign hit_take = hit && !stall;

  // job load and read issue
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      v1     <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= (q_rdata[JOB_W-1 -: IDX_W] != '0);
      end else if (ram_re && rd_idx == '0) begin
        active <= 1'b0;
      end
      if (!stall) begin
        v1 <= ram_re;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_box  <= q_rdata[BOX_W-1:0];
      job_prio <= q_rdata[BOX_W];
      job_pos  <= q_rdata[JOB_W-1 -: IDX_W];
      rd_idx   <= q_rdata[JOB_W-1 -: IDX_W] - IDX_W'(1);
    end else if (ram_re) begin
      rd_idx <= rd_idx - IDX_W'(1);
    end
    if (ram_re) begin
      idx1  <= rd_idx;
      last1 <= (rd_idx == '0);
    end
  end

  // pending hit; a stalled last hit still follows the held one, so that one stays open
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v     <= 1'b0;
      pend_final <= 1'b0;
    end else if (hit_take) begin
      pend_v     <= 1'b1;
      pend_final <= last1;
    end else if (pend_go) begin
      pend_v <= 1'b0;
    end else if (v1 && last1 && pend_v && !hit) begin
      pend_final <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_take) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        pend_lo[a] <= cand_lo[a];
        pend_hi[a] <= cand_hi[a];
      end
      pend_new <= job_pos;
      pend_old <= idx1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pend_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_go) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        out_c[a] <= {pend_lo[a][CB-1], pend_lo[a]} + {pend_hi[a][CB-1], pend_hi[a]};
      end
      out_new <= pend_new;
      out_old <= pend_old;
      m_tlast <= pend_final;
    end
  end

  assign m_tdata = M_DATA_W'({out_old, out_new, out_c[2], out_c[1], out_c[0]});

endmodule

@@ hw/rtl/box_overlap_pair_finder.sv @@
// a box passes the job queue, the box ram read and the compare stage; a hit is held, then registered at the output
// throughput: a box holding set position p has its p earlier boxes read in the back scan,
//   one stored box read per cycle from the box ram, plus stalls while results wait
// a start-of-set box waits at the input until earlier scans are done
// reset: clears the stored count, job queue and pipeline valids; the box ram is not
//   cleared, since only positions written in the current set are ever read
`include "box_overlap_pair_finder_macros.svh"

module box_overlap_pair_finder #(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  // box word input
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z, zero pad
  input  logic [((6*COORD_BITS+7)/8)*8-1:0]        s_tdata,
  // start_of_set, box_has_priority
  input  logic [bopf_pkg::S_USER_W-1:0]            s_tuser,
  // overlap word output
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // center_x_doubled, center_y_doubled, center_z_doubled, new_box_index,
  // earlier_box_index, zero pad
  output logic [((3*(COORD_BITS+1)+2*$clog2(MAX_BOXES)+7)/8)*8-1:0] m_tdata,
  // last_of_run
  output logic                                     m_tlast
);
  import bopf_pkg::*;

  localparam int IDX_W    = $clog2(MAX_BOXES);
  localparam int BOX_W    = NUM_BOUNDS * COORD_BITS;
  localparam int ENTRY_W  = BOX_W + 1;
  localparam int JOB_W    = ENTRY_W + IDX_W;
  localparam int S_DATA_W = ((6*COORD_BITS+7)/8)*8;
  localparam int M_DATA_W = ((3*(COORD_BITS+1)+2*IDX_W+7)/8)*8;

  // job queue between front and back
  qstat_t             q_stat;
  logic               q_push;
  logic               q_pop;
  logic [JOB_W-1:0]   q_wdata;
  logic [JOB_W-1:0]   q_rdata;
  logic               scan_idle;

  // box store
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // front: position assignment, store write, job push
  bopf_front #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IDX_W),
    .JOB_W      (JOB_W),
    .S_DATA_W   (S_DATA_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .scan_idle (scan_idle),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  bopf_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .q_stat (q_stat)
  );

  // one entry per set position: priority flag above the six bounds
  bopf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BOXES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // back: scan newest to oldest, one compare per cycle unless a held result stalls the scan
  bopf_back #(
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IDX_W),
    .JOB_W      (JOB_W),
    .M_DATA_W   (M_DATA_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .scan_idle (scan_idle),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // a new set must not overwrite entries that a queued or running scan still reads
  `BOPF_ASSERT_NOW(a_start_when_drained, s_tvalid && s_tready && s_tuser[USER_START], q_stat.empty && scan_idle, "start of set taken while scans pending")
  // no job push into a full queue
  `BOPF_ASSERT_NOW(a_no_push_full, q_push, !q_stat.full, "job pushed into full queue")
  // a popped job must have been there, and the queue is not full right after a pop with no push
  `BOPF_ASSERT_NOW(a_pop_nonempty, q_pop, !q_stat.empty, "job popped from empty queue")
  `BOPF_ASSERT_NEXT(a_pop_frees, q_pop && !q_push, !q_stat.full, "queue full after pop")

endmodule

@@ sim/tb_box_overlap_pair_finder.sv @@
// self-checking testbench for box_overlap_pair_finder: directed rows, then random box sets
// checks every overlap word against typed expected words or a built-in predictor of the pairwise box test
// depends on bopf_pkg and the box_overlap_pair_finder rtl
`timescale 1ns / 100ps

module tb_box_overlap_pair_finder;
  import bopf_pkg::*;

  localparam int MAX_BOXES    = 64;
  localparam int COORD_BITS   = 24;
  localparam int CW           = COORD_BITS + 1;       // doubled center width
  localparam int IW           = $clog2(MAX_BOXES);    // set position width
  localparam int S_W          = ((6*COORD_BITS+7)/8)*8;
  localparam int M_W          = ((3*CW+2*IW+7)/8)*8;
  localparam int C_MIN        = -(1 << (COORD_BITS-1));
  localparam int C_MAX        = (1 << (COORD_BITS-1)) - 1;
  localparam int RANDOM_ITEMS = 240;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {MODE_CLUSTER, MODE_SPARSE, MODE_NOISE, MODE_EXTREME, MODE_SPAN} box_mode_t;

  // one box word as the sender sees it, axis 0 is x
  typedef struct packed {
    logic                         start;
    logic                         prio;
    logic [2:0][COORD_BITS-1:0]   lo;
    logic [2:0][COORD_BITS-1:0]   hi;
  } box_t;

  // one overlap word as the receiver sees it
  typedef struct packed {
    logic [2:0][CW-1:0] center;
    logic [IW-1:0]      new_idx;
    logic [IW-1:0]      old_idx;
    logic               last;
  } overlap_t;

  typedef struct {
    box_t b;
    bit   typed;
  } directed_row_t;

  typedef struct {
    int       row;
    overlap_t word;
  } typed_word_t;

  logic clk;
  logic rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z
  logic [S_W-1:0]        s_tdata = '0;
  // start_of_set, box_has_priority
  logic [S_USER_W-1:0]   s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // center_x/y/z_doubled, new_box_index, earlier_box_index, zero pad
  logic [M_W-1:0]        m_tdata;
  // last_of_run
  logic                  m_tlast;

  // predictor copy of the stored set
  logic [2:0][COORD_BITS-1:0] stored_lo [MAX_BOXES];
  logic [2:0][COORD_BITS-1:0] stored_hi [MAX_BOXES];
  logic                       stored_prio [MAX_BOXES];
  int                         n_stored = 0;

  overlap_t      overlaps_due [$];   // overlap words still to come, oldest first
  directed_row_t directed_rows [$];
  typed_word_t   typed_words [$];
  string         axis_tag [3] = '{"x", "y", "z"};

  int          n_fail = 0;
  int unsigned cycles = 0;
  bit          tx_burst = 1'b0;     // sender runs without gaps
  bit          rx_burst = 1'b0;     // receiver runs without stalls
  int          rx_hold = 0;
  int          rx_draw;

  box_overlap_pair_finder #(
    .MAX_BOXES (MAX_BOXES),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // works out the overlap words one box causes and updates the stored set;
  // record low keeps the state in step without queueing words (typed rows)
  task automatic predict_overlaps(input box_t b, input bit record);
    int pos, j, a;
    bit full, meet, have_held;
    logic signed [CW-1:0] ln, hn, ls, hs;
    overlap_t word, held;
    if (b.start) n_stored = 0;
    full = (n_stored >= MAX_BOXES);
    // a full store treats the box as holding the last position
    pos = full ? MAX_BOXES - 1 : n_stored;
    have_held = 1'b0;
    held = '0;
    word = '0;
    // newest stored box first
    for (j = pos - 1; j >= 0; j--) begin
      meet = !(b.prio && stored_prio[j]);
      for (a = 0; a < 3; a++) begin
        ln = $signed(b.lo[a]);
        hn = $signed(b.hi[a]);
        ls = $signed(stored_lo[j][a]);
        hs = $signed(stored_hi[j][a]);
        // closed intervals; an inverted one holds no point of its own
        if (!((ln <= ls && ls <= hn) || (ln <= hs && hs <= hn) ||
              (ls <= ln && ln <= hs) || (ls <= hn && hn <= hs)))
          meet = 1'b0;
        word.center[a] = (ln > ls ? ln : ls) + (hn < hs ? hn : hs);
      end
      if (meet) begin
        word.new_idx = pos[IW-1:0];
        word.old_idx = j[IW-1:0];
        word.last    = 1'b0;
        if (have_held && record) overlaps_due.push_back(held);
        held = word;
        have_held = 1'b1;
      end
    end
    // last word of the run carries the flag
    if (have_held && record) begin
      held.last = 1'b1;
      overlaps_due.push_back(held);
    end
    if (!full) begin
      stored_lo[pos]   = b.lo;
      stored_hi[pos]   = b.hi;
      stored_prio[pos] = b.prio;
      n_stored = pos + 1;
    end
  endtask

  // drives one box word and waits for the handshake; valid stays high
  // when the next word follows with no gap
  task automatic send_box(input box_t b, input bit record);
    int gap;
    logic [S_USER_W-1:0] user;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    user = '0;
    user[USER_START] = b.start;
    user[USER_PRIO]  = b.prio;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b.hi[2], b.lo[2], b.hi[1], b.lo[1], b.hi[0], b.lo[0]};
    s_tuser  <= user;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_overlaps(b, record);
  endtask

  // holds the sender off until every queued overlap word has come
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (overlaps_due.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 6))
      0: return C_MIN;
      1: return C_MIN + 1;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return C_MAX - 1;
      default: return C_MAX;
    endcase
  endfunction

  function automatic box_t make_box(input box_mode_t mode, input bit start, input bit prio);
    box_t b;
    int a, lo, hi, t;
    b.start = start;
    b.prio  = prio;
    for (a = 0; a < 3; a++) begin
      case (mode)
        MODE_CLUSTER: begin
          // small boxes near the origin, so pairs meet often
          lo = int'($urandom_range(0, 200)) - 100;
          hi = lo + int'($urandom_range(0, 80));
          if ($urandom_range(0, 15) == 0) begin
            t = lo;
            lo = hi;
            hi = t;
          end
        end
        MODE_SPARSE: begin
          // tiny boxes spread over the whole range, rarely meeting
          lo = C_MIN + int'($urandom_range(0, (1 << COORD_BITS) - 4097));
          hi = lo + int'($urandom_range(0, 4095));
        end
        MODE_NOISE: begin
          lo = $urandom;
          hi = $urandom;
        end
        MODE_EXTREME: begin
          lo = pick_extreme();
          hi = pick_extreme();
        end
        default: begin
          lo = C_MIN;
          hi = C_MAX;
        end
      endcase
      b.lo[a] = lo[COORD_BITS-1:0];
      b.hi[a] = hi[COORD_BITS-1:0];
    end
    return b;
  endfunction

  function automatic void add_row(input bit typed, input bit start, input bit prio,
                                  input int xl, input int xh, input int yl, input int yh,
                                  input int zl, input int zh);
    directed_row_t r;
    r.typed   = typed;
    r.b.start = start;
    r.b.prio  = prio;
    r.b.lo[0] = xl[COORD_BITS-1:0];
    r.b.hi[0] = xh[COORD_BITS-1:0];
    r.b.lo[1] = yl[COORD_BITS-1:0];
    r.b.hi[1] = yh[COORD_BITS-1:0];
    r.b.lo[2] = zl[COORD_BITS-1:0];
    r.b.hi[2] = zh[COORD_BITS-1:0];
    directed_rows.push_back(r);
  endfunction

  function automatic void add_typed(input int row, input int cx, input int cy, input int cz,
                                    input int new_idx, input int old_idx, input bit last);
    typed_word_t t;
    t.row = row;
    t.word.center[0] = cx[CW-1:0];
    t.word.center[1] = cy[CW-1:0];
    t.word.center[2] = cz[CW-1:0];
    t.word.new_idx   = new_idx[IW-1:0];
    t.word.old_idx   = old_idx[IW-1:0];
    t.word.last      = last;
    typed_words.push_back(t);
  endfunction

  task automatic check_overlap_word();
    overlap_t got, want;
    int a;
    for (a = 0; a < 3; a++) got.center[a] = m_tdata[a*CW +: CW];
    got.new_idx = m_tdata[3*CW +: IW];
    got.old_idx = m_tdata[3*CW+IW +: IW];
    got.last    = m_tlast;
    if (overlaps_due.size() == 0) begin
      $error("overlap word with none due: tdata %h tlast %b", m_tdata, m_tlast);
      n_fail++;
    end else begin
      want = overlaps_due.pop_front();
      for (a = 0; a < 3; a++)
        if (got.center[a] !== want.center[a]) begin
          $error("center_%s_doubled: expected %0d, got %0d", axis_tag[a],
                 $signed(want.center[a]), $signed(got.center[a]));
          n_fail++;
        end
      if (got.new_idx !== want.new_idx) begin
        $error("new_box_index: expected %0d, got %0d", want.new_idx, got.new_idx);
        n_fail++;
      end
      if (got.old_idx !== want.old_idx) begin
        $error("earlier_box_index: expected %0d, got %0d", want.old_idx, got.old_idx);
        n_fail++;
      end
      if (got.last !== want.last) begin
        $error("last_of_run: expected %0d, got %0d", want.last, got.last);
        n_fail++;
      end
    end
  endtask

  // receiver: checks each overlap word, then draws a random stall before the next;
  // now and then flips into a stretch with no stalls at all
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold  <= 0;
    end else if (m_tvalid && m_tready) begin
      check_overlap_word();
      if ($urandom_range(0, 63) == 0) rx_burst <= !rx_burst;
      rx_draw = rx_burst ? 0 : $urandom_range(0, 11);
      m_tready <= (rx_draw == 0);
      rx_hold  <= rx_draw;
    end else if (!m_tready) begin
      if (rx_hold <= 1) m_tready <= 1'b1;
      rx_hold <= rx_hold - 1;
    end
  end

  initial begin
    int i, k, n_random, big_at, set_len, r;
    bit big_done, start, prio;
    box_t b;
    box_mode_t mode;

    // directed rows; typed ones carry their words, the rest go through the predictor
    // whole-range box after reset, no earlier box to meet
    add_row(1, 1, 0, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
    // whole-range priority box against a plain one: center is min + max on every axis
    add_row(1, 0, 1, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
    add_typed(1, -1, -1, -1, 1, 0, 1);
    // two priority boxes never pair, so only the plain one is hit
    add_row(1, 0, 1, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
    add_typed(2, -1, -1, -1, 2, 0, 1);
    // point at the top corner: largest doubled center
    add_row(1, 0, 0, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    add_typed(3, 2*C_MAX, 2*C_MAX, 2*C_MAX, 3, 2, 0);
    add_typed(3, 2*C_MAX, 2*C_MAX, 2*C_MAX, 3, 1, 0);
    add_typed(3, 2*C_MAX, 2*C_MAX, 2*C_MAX, 3, 0, 1);
    // point at the bottom corner: smallest doubled center, misses the top point
    add_row(1, 0, 0, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    add_typed(4, 2*C_MIN, 2*C_MIN, 2*C_MIN, 4, 2, 0);
    add_typed(4, 2*C_MIN, 2*C_MIN, 2*C_MIN, 4, 1, 0);
    add_typed(4, 2*C_MIN, 2*C_MIN, 2*C_MIN, 4, 0, 1);
    // new set starting with an inverted x interval
    add_row(1, 1, 0, 10, -10, 0, 10, 0, 10);
    // inverted interval caught by the other box's bounds
    add_row(0, 0, 1, -50, 50, 0, 10, 0, 10);
    // two inverted intervals never meet
    add_row(0, 0, 0, 100, -100, 0, 10, 0, 10);
    // bounds that touch count as overlap
    add_row(0, 0, 0, 10, 20, 10, 20, 10, 20);
    // one unit apart does not
    add_row(0, 0, 0, 11, 20, 11, 20, 11, 20);
    add_row(0, 0, 1, -1000, 1000, -1000, 1000, -1000, 1000);
    add_row(0, 0, 0, C_MIN, -8388000, 8388000, C_MAX, -5, 5);
    // priority-only set: no pairs, then a plain box meets both
    add_row(1, 1, 1, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, C_MIN, C_MAX, -3, 3, C_MAX, C_MIN);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < directed_rows.size(); i++) begin
      send_box(directed_rows[i].b, !directed_rows[i].typed);
      if (directed_rows[i].typed)
        for (k = 0; k < typed_words.size(); k++)
          if (typed_words[k].row == i) overlaps_due.push_back(typed_words[k].word);
    end
    // sender stays quiet until every overlap word is out
    wait_for_results();

    // random sets: mostly short well-formed sets, one set that overfills the store
    n_random = 0;
    big_done = 1'b0;
    big_at   = $urandom_range(20, 150);
    while (n_random < RANDOM_ITEMS) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) wait_for_results();
      if (!big_done && n_random >= big_at) begin
        // fill the store with scattered boxes, then boxes that run past the end
        for (k = 0; k < MAX_BOXES + 4; k++) begin
          prio = ($urandom_range(0, 2) == 0);
          if (k < MAX_BOXES)      b = make_box(MODE_SPARSE, k == 0, prio);
          else if (k == MAX_BOXES) b = make_box(MODE_SPAN, 1'b0, 1'b0);
          else if (k == MAX_BOXES + 1) b = make_box(MODE_SPAN, 1'b0, 1'b1);
          else if (k == MAX_BOXES + 2) b = make_box(MODE_NOISE, 1'b0, prio);
          else b = make_box(MODE_CLUSTER, 1'b0, prio);
          send_box(b, 1'b1);
          n_random++;
        end
        big_done = 1'b1;
      end else begin
        set_len = $urandom_range(1, 14);
        for (k = 0; k < set_len; k++) begin
          // a set mostly opens with the start flag; a stray start now and then
          start = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
          prio  = ($urandom_range(0, 2) == 0);
          r = $urandom_range(0, 19);
          if (r < 13)      mode = MODE_CLUSTER;
          else if (r < 15) mode = MODE_SPARSE;
          else if (r < 17) mode = MODE_NOISE;
          else if (r < 19) mode = MODE_EXTREME;
          else             mode = MODE_SPAN;
          send_box(make_box(mode, start, prio), 1'b1);
          n_random++;
        end
      end
    end

    // let the last runs drain, then watch for stray words
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0 && overlaps_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/bopf_pkg.sv
hw/rtl/bopf_ram.sv
hw/rtl/bopf_queue.sv
hw/rtl/bopf_front.sv
hw/rtl/bopf_back.sv
hw/rtl/box_overlap_pair_finder.sv
sim/tb_box_overlap_pair_finder.sv
